[rtl/core/slid_pkg.sv]
// Shared types and codes for the sorted list insert/delete block.
// Depends on nothing; imported by the top level.
`default_nettype none

package slid_pkg;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_INS     = 6'b000010,
        S_INS_PUT = 6'b000100,
        S_DEL     = 6'b001000,
        S_LIST    = 6'b010000,
        S_LWAIT   = 6'b100000
    } state_t;

endpackage : slid_pkg

`default_nettype wire

[rtl/core/sorted_list_insert_delete.sv]
// Sorted list store with insert and delete, listing the whole store after each command.
// Depends on slid_pkg and slid_ram.
// One command word at a time. The store pass reads the RAM one entry a cycle: insert
// walks down from the top, delete walks up; listing then gives one word a cycle while
// the master side is not stalling. The RAM read port sets this pace.
// Reset empties the list; store contents need no reset.
`default_nettype none

module sorted_list_insert_delete #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tuser,   // [0] cmd
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] element_value, [33:32] status,
                                        // [38:34] entry_count, [39] zero
    output logic             m_tuser,   // [0] element_valid
    output logic             m_tlast
);

    import slid_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    state_t               state_reg, state_next;
    logic signed [31:0]   value_reg, value_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 found_reg, found_next;
    logic [1:0]           status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [31:0]   out_value_reg, out_value_next;
    logic                 out_elem_reg, out_elem_next;
    logic                 out_last_reg, out_last_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [CW-1:0]        out_count_reg, out_count_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [31:0]          ram_wdata, ram_rdata;
    logic signed [31:0]   rd_val;

    logic                 accept, out_free;
    logic [CW-1:0]        cnt_m1;
    logic                 at_end;

    slid_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val   = $signed(ram_rdata);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign cnt_m1   = count_reg - CW'(1);
    assign at_end   = (CW'(idx_reg) == cnt_m1);

    always_comb
    begin
        state_next      = state_reg;
        value_next      = value_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_elem_next   = out_elem_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next  = $signed(s_tdata);
                    status_next = ST_DONE;
                    found_next  = 1'b0;
                    if (s_tuser == CMD_INSERT)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_LIST;
                        end
                        else if (count_reg == '0)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = s_tdata;
                            count_next = CW'(1);
                            state_next = S_LIST;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(cnt_m1);
                            idx_next   = AW'(cnt_m1);
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_NOTFOUND;
                            state_next  = S_LIST;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            idx_next   = '0;
                            state_next = S_DEL;
                        end
                    end
                end
            end

            // walking down: entries above the value move up by one
            S_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + AW'(1);
                if (rd_val > value_reg)
                begin
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = idx_reg - AW'(1);
                        idx_next   = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    ram_wdata  = value_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_LIST;
                end
            end

            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = value_reg;
                count_next = count_reg + CW'(1);
                state_next = S_LIST;
            end

            // walking up: after the first match, every entry moves down by one
            S_DEL:
            begin
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                else if (rd_val == value_reg)
                begin
                    found_next = 1'b1;
                end
                if (at_end)
                begin
                    if (found_reg || (rd_val == value_reg))
                    begin
                        count_next = cnt_m1;
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    state_next = S_LIST;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end

            S_LIST:
            begin
                if (count_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_elem_next   = 1'b0;
                        out_last_next   = 1'b1;
                        out_status_next = status_reg;
                        out_count_next  = count_reg;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    idx_next   = '0;
                    state_next = S_LWAIT;
                end
            end

            S_LWAIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_val;
                    out_elem_next   = 1'b1;
                    out_last_next   = at_end;
                    out_status_next = status_reg;
                    out_count_next  = count_reg;
                    if (at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + AW'(1);
                        idx_next  = idx_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_elem_reg   <= out_elem_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // status and count are fixed for the whole listing of a command
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, COUNT_W'(out_count_reg), out_status_reg, out_value_reg};
    assign m_tuser  = out_elem_reg;
    assign m_tlast  = out_last_reg;

endmodule : sorted_list_insert_delete

`default_nettype wire

[rtl/core/slid_ram.sv]
// Single-port-write, single-port-read synchronous store, registered read data.
// Standalone; used by sorted_list_insert_delete.
`default_nettype none

module slid_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : slid_ram

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for sorted_list_insert_delete: directed table then random commands.
// Depends on slid_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module testbench;

    import slid_pkg::*;

    localparam int unsigned LIST_DEPTH   = 16;
    localparam int          RANDOM_ITEMS = 436;
    localparam int          PHASE_ITEMS  = RANDOM_ITEMS / 4;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE       = 2 * LIST_DEPTH + 16;

    // one listing word as it should leave the block
    typedef struct packed {
        logic [31:0] value;
        logic        valid;
        logic [1:0]  status;
        logic [4:0]  count;
        logic        last;
    } listing_word_t;

    // directed row; status and count are checked as typed when fixed is set
    typedef struct packed {
        logic        cmd;
        logic [31:0] value;
        logic        fixed;
        logic [1:0]  status;
        logic [4:0]  count;
    } command_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam command_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_DELETE, 32'h0000_0000, 1'b1, ST_NOTFOUND, 5'd0},  // delete on empty list
        '{CMD_INSERT, 32'h7fff_ffff, 1'b1, ST_DONE,     5'd1},
        '{CMD_INSERT, 32'h8000_0000, 1'b1, ST_DONE,     5'd2},
        '{CMD_INSERT, 32'h0000_0000, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'h0000_0000, 1'b0, ST_DONE,     5'd0},  // duplicate goes after
        '{CMD_INSERT, 32'hffff_ffff, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'h7fff_ffff, 1'b1, ST_DONE,     5'd6},  // largest again, at end
        '{CMD_DELETE, 32'h0000_0000, 1'b0, ST_DONE,     5'd0},
        '{CMD_DELETE, 32'h0000_3039, 1'b1, ST_NOTFOUND, 5'd5},
        '{CMD_INSERT, 32'h5555_5555, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'haaaa_aaaa, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'h0000_0001, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'h0000_0002, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'hffff_fffe, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'h0000_0064, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'hffff_ff9c, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'h1234_5678, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'hedcb_a987, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'h0000_0007, 1'b0, ST_DONE,     5'd0},
        '{CMD_INSERT, 32'hffff_fff9, 1'b1, ST_DONE,     5'd16},
        '{CMD_INSERT, 32'h0000_0003, 1'b1, ST_FULL,     5'd16}, // store full
        '{CMD_DELETE, 32'h8000_0000, 1'b1, ST_DONE,     5'd15},
        '{CMD_DELETE, 32'h7fff_ffff, 1'b1, ST_DONE,     5'd14},
        '{CMD_INSERT, 32'h8000_0000, 1'b1, ST_DONE,     5'd15}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // [31:0] element_value, [33:32] status, [38:34] entry_count
    logic        m_tuser;   // [0] element_valid
    logic        m_tlast;

    // shadow of the sorted store
    logic signed [31:0] shadow_list [LIST_DEPTH];
    int                 shadow_len = 0;

    listing_word_t pending_words [$];

    int errors        = 0;
    int words_checked = 0;
    int n_inserts     = 0;
    int n_deletes     = 0;
    int n_refused     = 0;
    int n_not_found   = 0;
    int n_empty       = 0;
    int n_full_lists  = 0;
    int cycles        = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;

    sorted_list_insert_delete #(
        .DEPTH    (LIST_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // apply one command to the shadow store and queue the listing it produces
    task automatic apply_and_list(input logic cmd, input logic [31:0] value,
                                  input logic fixed, input logic [1:0] fixed_status,
                                  input logic [4:0] fixed_count);
        logic signed [31:0] v;
        logic [1:0]         status;
        logic [4:0]         count;
        int                 pos;
        listing_word_t      word;
        v      = value;
        status = ST_DONE;
        if (cmd == CMD_INSERT)
        begin
            n_inserts++;
            if (shadow_len >= LIST_DEPTH)
            begin
                status = ST_FULL;
                n_refused++;
            end
            else
            begin
                // after any equal entries
                pos = shadow_len;
                for (int k = shadow_len - 1; k >= 0; k--)
                    if (v < shadow_list[k])
                        pos = k;
                for (int k = shadow_len; k > pos; k--)
                    shadow_list[k] = shadow_list[k - 1];
                shadow_list[pos] = v;
                shadow_len++;
            end
        end
        else
        begin
            n_deletes++;
            pos = -1;
            for (int k = shadow_len - 1; k >= 0; k--)
                if (shadow_list[k] == v)
                    pos = k;
            if (pos < 0)
            begin
                status = ST_NOTFOUND;
                n_not_found++;
            end
            else
            begin
                for (int k = pos; k + 1 < shadow_len; k++)
                    shadow_list[k] = shadow_list[k + 1];
                shadow_len--;
            end
        end
        count = shadow_len[4:0];
        if (fixed)
        begin
            status = fixed_status;
            count  = fixed_count;
        end
        if (shadow_len == LIST_DEPTH)
            n_full_lists++;
        if (shadow_len == 0)
        begin
            n_empty++;
            word = '{value: '0, valid: 1'b0, status: status, count: count, last: 1'b1};
            pending_words.push_back(word);
        end
        for (int k = 0; k < shadow_len; k++)
        begin
            word = '{value: shadow_list[k], valid: 1'b1, status: status, count: count,
                     last: (k == shadow_len - 1)};
            pending_words.push_back(word);
        end
    endtask

    // offer one command word, with a random gap first, and wait for the handshake
    task automatic send_command(input logic cmd, input logic [31:0] value,
                                input logic fixed, input logic [1:0] fixed_status,
                                input logic [4:0] fixed_count);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_and_list(cmd, value, fixed, fixed_status, fixed_count);
    endtask

    // small values give plenty of duplicates
    function automatic logic [31:0] pick_value();
        int sel;
        int small_val;
        sel = $urandom_range(9);
        case (sel)
            0:
            begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            1, 2:    return $urandom;
            default:
            begin
                small_val = int'($urandom_range(16)) - 8;
                return small_val;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        listing_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, got %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                check_field("element_value", want.value, m_tdata[31:0]);
                check_field("element_valid", 32'(want.valid), 32'(m_tuser));
                check_field("status", 32'(want.status), 32'(m_tdata[33:32]));
                check_field("entry_count", 32'(want.count), 32'(m_tdata[38:34]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d words outstanding", $time,
                     pending_words.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic cmd;
        logic [31:0] value;
        bit   filling;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_command(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].fixed,
                         DIRECTED[i].status, DIRECTED[i].count);

        // random part: drift between empty and full so both ends are exercised
        filling = 1'b0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct <= 0;  stall_pct <= 0;  end
                1:       begin idle_pct <= 72; stall_pct <= 0;  end
                2:       begin idle_pct <= 0;  stall_pct <= 72; end
                default: begin idle_pct <= 38; stall_pct <= 38; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (shadow_len == LIST_DEPTH && $urandom_range(3) == 0)
                    filling = 1'b0;
                else if (shadow_len == 0 && $urandom_range(2) == 0)
                    filling = 1'b1;
                else if ($urandom_range(39) == 0)
                    filling = !filling;
                cmd = ($urandom_range(99) < (filling ? 75 : 25)) ? CMD_INSERT : CMD_DELETE;
                if (cmd == CMD_DELETE && shadow_len > 0 && $urandom_range(9) < 8)
                    value = shadow_list[$urandom_range(shadow_len - 1)];
                else
                    value = pick_value();
                send_command(cmd, value, 1'b0, ST_DONE, 5'd0);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d inserts (%0d refused when full), %0d deletes (%0d not found)",
                 n_inserts, n_refused, n_deletes, n_not_found);
        $display("%0d listing words checked, %0d empty listings, %0d full listings",
                 words_checked, n_empty, n_full_lists);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
